FILE: sv/sclr_pkg.sv
// Shared constants and codes for the sphere clearance classifier.
`timescale 1ns / 1ps
package sclr_pkg;

	localparam int MAX_OBSTACLES_DEF = 64;

	localparam int COORD_W  = 16;
	localparam int RADIUS_W = 15;
	localparam int INDEX_W  = 6;
	localparam int COUNT_W  = 7;
	localparam int THR_W    = 15;
	localparam int CLEAR_W  = 18;
	localparam int STATUS_W = 2;

	localparam logic [THR_W-1:0]   THR_RESET   = 15'd160;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd0;

	// clearance reported when no enabled obstacle was examined
	localparam logic signed [19:0] CLEAR_MAX = 20'sd131071;

	typedef enum logic [0:0] {
		REG_NEAR_THRESHOLD = 1'b0,
		REG_OBSTACLE_COUNT = 1'b1
	} reg_index_t;

	typedef enum logic [0:0] {
		MODE_WRITE = 1'b0,
		MODE_QUERY = 1'b1
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_SAFE      = 2'd0,
		STATUS_NEAR      = 2'd1,
		STATUS_COLLISION = 2'd2
	} status_t;

endpackage

FILE: sv/sphere_clearance_classifier.sv
// Top level: obstacle table memory, distance sequencer and result register.
`timescale 1ns / 1ps
// Sphere clearance classifier. Input words on s_axis carry either an obstacle
// write (tuser mode 0) or a point query (mode 1). A write goes straight into the
// obstacle table and gives no output word. A query walks table entries
// 0 .. min(obstacle_count, MAX_OBSTACLES)-1 through one synchronous memory
// read port: a disabled entry is read and skipped, an enabled one goes through
// read, difference, three squares through one shared multiplier, an 18-step
// bit-serial floor square root and compare. The result waits in an output
// register, so the next input word is taken while the previous result is
// still pending. Table entries that were never written read as garbage; write
// every entry a query will examine. Configuration: index 0 near_threshold,
// index 1 obstacle_count.
module sphere_clearance_classifier #(
	parameter int MAX_OBSTACLES = sclr_pkg::MAX_OBSTACLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [5:0] entry_index, [21:6] coord_x, [37:22] coord_y, [53:38] coord_z,
	// [68:54] sphere_radius, [69] entry_enabled, [71:70] zero
	input  logic [71:0] s_axis_tdata,
	// [0] mode
	input  logic [0:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [17:0] nearest_clearance, [35:18] effective_clearance,
	// [37:36] proximity_class, [38] no_obstacle, [39] zero
	output logic [39:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [14:0] cfg_data
);

	localparam int IDXW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
	localparam int CW   = $clog2(MAX_OBSTACLES + 1);
	localparam int LW   = (CW > 11) ? CW : 11;
	localparam int ENTRY_W = 3 * sclr_pkg::COORD_W + 16;
	localparam int RW   = 36;

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_DIFF, S_SQ, S_ROOT, S_CMP, S_OUT
	} state_t;

	// unpack input word
	logic [5:0]         in_idx;
	logic signed [15:0] in_x, in_y, in_z;
	logic [14:0]        in_rad;
	logic               in_en;
	assign in_idx = s_axis_tdata[5:0];
	assign in_x   = s_axis_tdata[21:6];
	assign in_y   = s_axis_tdata[37:22];
	assign in_z   = s_axis_tdata[53:38];
	assign in_rad = s_axis_tdata[68:54];
	assign in_en  = s_axis_tdata[69];

	state_t state_q;
	logic [14:0]        thr_q;
	logic [6:0]         count_q;
	logic [CW-1:0]      lim_q, cnt_q;
	logic signed [15:0] px_q, py_q, pz_q;
	logic [14:0]        qrad_q, orad_q;
	logic signed [16:0] dx_q, dy_q, dz_q;
	logic [1:0]         step_q;
	logic [4:0]         rstep_q;
	logic [RW-1:0]      v_q, res_q, bit_q;
	logic signed [19:0] nearest_q;
	logic               found_q;
	logic               out_valid_q;
	logic [39:0]        out_data_q;
	logic               out_load;

	// obstacle table: {enable, radius, z, y, x}
	logic [ENTRY_W-1:0] mem [MAX_OBSTACLES];
	logic [ENTRY_W-1:0] rd_data_q;
	logic               wr_en;
	logic [IDXW-1:0]    wr_addr, rd_addr;
	logic               in_fire;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign wr_en     = in_fire && (s_axis_tuser[0] == sclr_pkg::MODE_WRITE)
	                && ({{(LW-6){1'b0}}, in_idx} < LW'(MAX_OBSTACLES));
	assign wr_addr   = IDXW'(in_idx);
	assign rd_addr   = cnt_q[IDXW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {in_en, in_rad, in_z, in_y, in_x};
		end
		rd_data_q <= mem[rd_addr];
	end

	// one shared multiplier; step picks the axis
	logic signed [16:0] sq_op;
	logic signed [33:0] sq_prod;
	always_comb begin
		case (step_q)
			2'd0:    sq_op = dx_q;
			2'd1:    sq_op = dy_q;
			default: sq_op = dz_q;
		endcase
	end
	assign sq_prod = sq_op * sq_op;

	// one step of the floor root
	logic [RW-1:0] trial;
	assign trial = res_q + bit_q;

	// clearance of current obstacle and final result
	logic signed [19:0] clr;
	logic signed [20:0] eff_raw;
	logic signed [19:0] eff, near_out;
	logic [1:0]         status;
	assign clr = $signed({2'b00, res_q[17:0]}) - $signed({5'b00000, orad_q});
	assign eff_raw = {nearest_q[19], nearest_q} - $signed({6'b000000, qrad_q});
	always_comb begin
		if (!found_q) begin
			near_out = sclr_pkg::CLEAR_MAX;
			eff      = sclr_pkg::CLEAR_MAX;
		end else begin
			near_out = nearest_q;
			if (eff_raw > 21'(sclr_pkg::CLEAR_MAX)) eff = sclr_pkg::CLEAR_MAX;
			else eff = eff_raw[19:0];
		end
		if (eff < 0) status = sclr_pkg::STATUS_COLLISION;
		else if (eff < $signed({5'b00000, thr_q})) status = sclr_pkg::STATUS_NEAR;
		else status = sclr_pkg::STATUS_SAFE;
	end

	logic [LW-1:0] cnt_ext;
	assign cnt_ext = {{(LW-7){1'b0}}, count_q};

	// load the result when the output register is free or drains this cycle
	assign out_load = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			thr_q       <= sclr_pkg::THR_RESET;
			count_q     <= sclr_pkg::COUNT_RESET;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			cnt_q       <= '0;
			lim_q       <= '0;
			step_q      <= '0;
			rstep_q     <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					sclr_pkg::REG_NEAR_THRESHOLD: thr_q   <= cfg_data;
					sclr_pkg::REG_OBSTACLE_COUNT: count_q <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_fire && s_axis_tuser[0] == sclr_pkg::MODE_QUERY) begin
						px_q      <= in_x;
						py_q      <= in_y;
						pz_q      <= in_z;
						qrad_q    <= in_rad;
						cnt_q     <= '0;
						found_q   <= 1'b0;
						nearest_q <= sclr_pkg::CLEAR_MAX;
						lim_q     <= (cnt_ext > LW'(MAX_OBSTACLES)) ? CW'(MAX_OBSTACLES)
						                                           : CW'(cnt_ext);
						state_q   <= S_READ;
					end
				end
				S_READ: begin
					// address of cnt_q goes to the memory this cycle
					if (cnt_q == lim_q) state_q <= S_OUT;
					else state_q <= S_DIFF;
				end
				S_DIFF: begin
					if (!rd_data_q[ENTRY_W-1]) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_READ;
					end else begin
						dx_q    <= 17'(px_q) - 17'($signed(rd_data_q[15:0]));
						dy_q    <= 17'(py_q) - 17'($signed(rd_data_q[31:16]));
						dz_q    <= 17'(pz_q) - 17'($signed(rd_data_q[47:32]));
						orad_q  <= rd_data_q[62:48];
						v_q     <= '0;
						step_q  <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					v_q    <= v_q + RW'(unsigned'(sq_prod));
					step_q <= step_q + 1'b1;
					if (step_q == 2'd2) begin
						res_q   <= '0;
						bit_q   <= RW'(1) << (RW - 2);
						rstep_q <= '0;
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (v_q >= trial) begin
						v_q   <= v_q - trial;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q   <= bit_q >> 2;
					rstep_q <= rstep_q + 1'b1;
					if (rstep_q == 5'(RW / 2 - 1)) state_q <= S_CMP;
				end
				S_CMP: begin
					if (!found_q || clr < nearest_q) nearest_q <= clr;
					found_q <= 1'b1;
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_READ;
				end
				S_OUT: begin
					// hold until the output register is free
					if (out_load) begin
						out_data_q  <= {1'b0, !found_q, status, eff[17:0], near_out[17:0]};
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
